// ===== rtl/imtsq_pkg.sv =====
package imtsq_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam int unsigned RDepth = 4;
  localparam int unsigned RPtrW = $clog2(RDepth);
  localparam int unsigned RCntW = $clog2(RDepth + 1);

  localparam logic [7:0] StMask      = 8'hF8;
  localparam logic [7:0] StStart     = 8'h08;
  localparam logic [7:0] StRepStart  = 8'h10;
  localparam logic [7:0] StWrAddrAck = 8'h18;
  localparam logic [7:0] StWrDataAck = 8'h28;
  localparam logic [7:0] StRdAddrAck = 8'h40;
  localparam logic [7:0] StRxAck     = 8'h50;
  localparam logic [7:0] StRxNack    = 8'h58;

  typedef enum logic [1:0] {
    CMD_BEGIN_RD = 2'd0,
    CMD_BEGIN_WR = 2'd1,
    CMD_EVENT    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_RXACK = 3'd3,
    ACT_RXNAK = 3'd4,
    ACT_STOP  = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_START  = 3'd1,
    ERR_ADDR   = 3'd2,
    ERR_DATA   = 3'd3,
    ERR_RXACK  = 3'd4,
    ERR_RXLAST = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_ADDR    = 3'd2,
    PH_DATA    = 3'd3,
    PH_RX_ACK  = 3'd4,
    PH_RX_LAST = 3'd5
  } phase_e;

  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_EVENT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    STC_START,
    STC_REP_START,
    STC_WR_ADDR_ACK,
    STC_WR_DATA_ACK,
    STC_RD_ADDR_ACK,
    STC_RX_ACK,
    STC_RX_NACK,
    STC_OTHER
  } stc_e;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] slave_address;
    logic [7:0] byte_count;
    logic       send_stop;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] action_byte;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       done_res;
    logic [2:0] error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    kind_e      kind;
    logic       is_read;
    logic [7:0] addr_byte;
    logic [7:0] count;
    logic       stop;
    stc_e       stat;
    logic [7:0] rx;
    logic [7:0] tx;
  } cls_t;

endpackage

// ===== rtl/imtsq_front.sv =====
module imtsq_front
  import imtsq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  output logic item_valid_o,
  output cls_t item_o,
  input  logic item_pop_i
);

  cls_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  cls_t             cls;
  logic             keep;
  logic             wr_en;
  logic             rd_en;

  always_comb begin
    cls.kind      = (req_i.command == CMD_EVENT) ? KIND_EVENT : KIND_BEGIN;
    cls.is_read   = (req_i.command == CMD_BEGIN_RD);
    cls.addr_byte = {req_i.slave_address, cls.is_read};
    cls.count     = (cls.is_read && req_i.byte_count == 8'd0) ? 8'd1 : req_i.byte_count;
    cls.stop      = req_i.send_stop;
    cls.rx        = req_i.rx_byte;
    cls.tx        = req_i.tx_byte;
    unique case (req_i.bus_status & StMask)
      StStart:     cls.stat = STC_START;
      StRepStart:  cls.stat = STC_REP_START;
      StWrAddrAck: cls.stat = STC_WR_ADDR_ACK;
      StWrDataAck: cls.stat = STC_WR_DATA_ACK;
      StRdAddrAck: cls.stat = STC_RD_ADDR_ACK;
      StRxAck:     cls.stat = STC_RX_ACK;
      StRxNack:    cls.stat = STC_RX_NACK;
      default:     cls.stat = STC_OTHER;
    endcase
  end

  // Code three produces nothing, so it is dropped here.
  assign keep   = (req_i.command != CMD_NONE);
  assign full_o = (cnt_q == QCntW'(QDepth));
  assign wr_en  = push_i && !full_o && keep;
  assign rd_en  = item_pop_i && item_valid_o;

  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(wr_en) - QCntW'(rd_en);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/imtsq_back.sv =====
module imtsq_back
  import imtsq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic item_valid_i,
  input  cls_t item_i,
  output logic item_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  phase_e     phase_q, phase_d;
  logic       is_read_q, is_read_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       stop_q, stop_d;
  logic       rep_pend_q, rep_pend_d;
  logic [7:0] addr_byte_q, addr_byte_d;
  logic       fail_q, fail_d;
  logic [1:0] fail_cnt_q, fail_cnt_d;
  err_e       err_q, err_d;

  logic       go;
  logic       is_begin;
  logic       exp_ok;
  err_e       fail_code;
  logic [7:0] bl_dec;

  assign go         = item_valid_i && !fail_q && !res_full_i;
  assign is_begin   = (item_i.kind == KIND_BEGIN);
  assign bl_dec     = bytes_left_q - 8'd1;
  assign item_pop_o = go;

  always_comb begin
    unique case (phase_q)
      PH_START: begin
        exp_ok    = rep_pend_q ? (item_i.stat == STC_REP_START) : (item_i.stat == STC_START);
        fail_code = ERR_START;
      end
      PH_ADDR: begin
        exp_ok    = is_read_q ? (item_i.stat == STC_RD_ADDR_ACK)
                              : (item_i.stat == STC_WR_ADDR_ACK);
        fail_code = ERR_ADDR;
      end
      PH_DATA: begin
        exp_ok    = (item_i.stat == STC_WR_DATA_ACK);
        fail_code = ERR_DATA;
      end
      PH_RX_ACK: begin
        exp_ok    = (item_i.stat == STC_RX_ACK);
        fail_code = ERR_RXACK;
      end
      PH_RX_LAST: begin
        exp_ok    = (item_i.stat == STC_RX_NACK);
        fail_code = ERR_RXLAST;
      end
      default: begin
        exp_ok    = 1'b1;
        fail_code = ERR_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    is_read_d    = is_read_q;
    bytes_left_d = bytes_left_q;
    stop_d       = stop_q;
    rep_pend_d   = rep_pend_q;
    addr_byte_d  = addr_byte_q;
    fail_d       = fail_q;
    fail_cnt_d   = fail_cnt_q;
    err_d        = err_q;
    if (fail_q) begin
      if (!res_full_i) begin
        fail_cnt_d = fail_cnt_q + 2'd1;
        if (fail_cnt_q == 2'd3) begin
          fail_d = 1'b0;
        end
      end
    end else if (go) begin
      if (is_begin) begin
        if (phase_q == PH_IDLE) begin
          is_read_d    = item_i.is_read;
          addr_byte_d  = item_i.addr_byte;
          bytes_left_d = item_i.count;
          stop_d       = item_i.stop;
          phase_d      = PH_START;
        end
      end else if (phase_q != PH_IDLE) begin
        if (!exp_ok) begin
          fail_d     = 1'b1;
          fail_cnt_d = 2'd1;
          err_d      = fail_code;
          rep_pend_d = 1'b0;
          phase_d    = PH_IDLE;
        end else begin
          unique case (phase_q)
            PH_START: phase_d = PH_ADDR;
            PH_ADDR, PH_DATA: begin
              if (is_read_q && phase_q == PH_ADDR) begin
                phase_d = (bytes_left_q > 8'd1) ? PH_RX_ACK : PH_RX_LAST;
              end else if (bytes_left_q == 8'd0) begin
                phase_d    = PH_IDLE;
                rep_pend_d = !stop_q;
              end else begin
                bytes_left_d = bl_dec;
                phase_d      = PH_DATA;
              end
            end
            PH_RX_ACK: begin
              bytes_left_d = bl_dec;
              phase_d      = (bl_dec > 8'd1) ? PH_RX_ACK : PH_RX_LAST;
            end
            PH_RX_LAST: begin
              bytes_left_d = 8'd0;
              phase_d      = PH_IDLE;
              rep_pend_d   = !stop_q;
            end
            default: phase_d = phase_q;
          endcase
        end
      end
    end
  end

  // Result.
  always_comb begin
    res_o      = '0;
    res_push_o = 1'b0;
    if (fail_q) begin
      res_push_o       = !res_full_i;
      res_o.bus_action = ACT_STOP;
      res_o.error_code = err_q;
      res_o.done_res   = (fail_cnt_q == 2'd3);
      res_o.last       = (fail_cnt_q == 2'd3);
    end else if (go) begin
      res_o.last = 1'b1;
      if (is_begin) begin
        if (phase_q == PH_IDLE) begin
          res_push_o       = 1'b1;
          res_o.bus_action = ACT_START;
        end
      end else if (phase_q != PH_IDLE) begin
        res_push_o = 1'b1;
        if (!exp_ok) begin
          res_o.bus_action = ACT_STOP;
          res_o.error_code = fail_code;
          res_o.last       = 1'b0;
        end else begin
          unique case (phase_q)
            PH_START: begin
              res_o.bus_action  = ACT_SEND;
              res_o.action_byte = addr_byte_q;
            end
            PH_ADDR, PH_DATA: begin
              if (is_read_q && phase_q == PH_ADDR) begin
                res_o.bus_action = (bytes_left_q > 8'd1) ? ACT_RXACK : ACT_RXNAK;
              end else if (bytes_left_q == 8'd0) begin
                res_o.bus_action = stop_q ? ACT_STOP : ACT_NONE;
                res_o.done_res   = 1'b1;
              end else begin
                res_o.bus_action  = ACT_SEND;
                res_o.action_byte = item_i.tx;
              end
            end
            PH_RX_ACK: begin
              res_o.bus_action = (bl_dec > 8'd1) ? ACT_RXACK : ACT_RXNAK;
              res_o.rx_data    = item_i.rx;
              res_o.rx_valid   = 1'b1;
            end
            PH_RX_LAST: begin
              res_o.bus_action = stop_q ? ACT_STOP : ACT_NONE;
              res_o.rx_data    = item_i.rx;
              res_o.rx_valid   = 1'b1;
              res_o.done_res   = 1'b1;
            end
            default: res_o.bus_action = ACT_NONE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      is_read_q    <= 1'b0;
      bytes_left_q <= 8'd0;
      stop_q       <= 1'b0;
      rep_pend_q   <= 1'b0;
      addr_byte_q  <= 8'd0;
      fail_q       <= 1'b0;
      fail_cnt_q   <= 2'd0;
      err_q        <= ERR_OK;
    end else begin
      phase_q      <= phase_d;
      is_read_q    <= is_read_d;
      bytes_left_q <= bytes_left_d;
      stop_q       <= stop_d;
      rep_pend_q   <= rep_pend_d;
      addr_byte_q  <= addr_byte_d;
      fail_q       <= fail_d;
      fail_cnt_q   <= fail_cnt_d;
      err_q        <= err_d;
    end
  end

endmodule

// ===== rtl/imtsq_res_fifo.sv =====
module imtsq_res_fifo
  import imtsq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t data_o
);

  res_t             mem_q [RDepth];
  logic [RPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [RCntW-1:0] cnt_q, cnt_d;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = (cnt_q == RCntW'(RDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + RCntW'(wr_en) - RCntW'(rd_en);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/i2c_master_transaction_sequencer_core.sv =====
// Sequencer for I2C master transactions on top of a byte-level bus engine.
// Input channel: drive req_i and raise push; the item is taken at a clock
// edge where push is high and full is low. Begin commands and bus events
// from the engine share this channel.
// Result channel: while empty is low, res_o holds the oldest result; it is
// taken at a clock edge where pop is high and empty is low. An item gives
// zero, one or four results, and last marks the final one of each item.
// A taken item is registered in the input queue, and its results in the
// result queue. Throughput: one item per cycle while the result queue has
// room; a failed check stalls until four stop results are written.
// A two-entry input queue decouples classification from the sequencer,
// and a four-entry result queue decouples the sequencer from the receiver.
// When the receiver stalls, the result queue fills, the sequencer halts,
// and full rises once the input queue is full; nothing is lost.
// Reset empties both queues and returns the sequencer to idle with no
// repeated start pending.
module i2c_master_transaction_sequencer_core
  import imtsq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  logic item_valid;
  cls_t item;
  logic item_pop;
  logic res_full;
  logic res_push;
  res_t res;

  imtsq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .req_i        (req_i),
    .full_o       (full),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  imtsq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  imtsq_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_o)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb
  import imtsq_pkg::*;
();

  localparam int unsigned StallLimit = 2000;

  class seq_tracker;
    phase_e      phase;
    bit          is_read;
    bit [7:0]    bytes_left;
    bit          stop_wanted;
    bit          rep_pending;
    bit [7:0]    addr_byte;
    res_t        actions_due[$];
    int unsigned errors;
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_aborts;
    int unsigned n_rx;

    function new();
      phase       = PH_IDLE;
      is_read     = 1'b0;
      bytes_left  = 8'd0;
      stop_wanted = 1'b0;
      rep_pending = 1'b0;
      addr_byte   = 8'd0;
      errors      = 0;
      n_items     = 0;
      n_results   = 0;
      n_aborts    = 0;
      n_rx        = 0;
    endfunction

    function void add(act_e act, logic [7:0] abyte, logic [7:0] rxd, logic rxv, logic done,
                      err_e err, logic lst);
      res_t r;
      r.bus_action  = act;
      r.action_byte = abyte;
      r.rx_data     = rxd;
      r.rx_valid    = rxv;
      r.done_res    = done;
      r.error_code  = err;
      r.last        = lst;
      actions_due.push_back(r);
    endfunction

    function logic [7:0] wanted_status();
      case (phase)
        PH_START:   wanted_status = rep_pending ? StRepStart : StStart;
        PH_ADDR:    wanted_status = is_read ? StRdAddrAck : StWrAddrAck;
        PH_DATA:    wanted_status = StWrDataAck;
        PH_RX_ACK:  wanted_status = StRxAck;
        PH_RX_LAST: wanted_status = StRxNack;
        default:    wanted_status = StStart;
      endcase
    endfunction

    function void finish_ok(logic [7:0] rxd, logic rxv);
      act_e act;
      if (stop_wanted) begin
        act = ACT_STOP;
        rep_pending = 1'b0;
      end else begin
        act = ACT_NONE;
        rep_pending = 1'b1;
      end
      phase = PH_IDLE;
      add(act, 8'd0, rxd, rxv, 1'b1, ERR_OK, 1'b1);
    endfunction

    function void abort(err_e err);
      for (int k = 0; k < 4; k++) begin
        add(ACT_STOP, 8'd0, 8'd0, 1'b0, k == 3, err, k == 3);
      end
      rep_pending = 1'b0;
      phase = PH_IDLE;
      n_aborts++;
    endfunction

    function void next_read(logic [7:0] rxd, logic rxv);
      if (bytes_left > 8'd1) begin
        phase = PH_RX_ACK;
        add(ACT_RXACK, 8'd0, rxd, rxv, 1'b0, ERR_OK, 1'b1);
      end else begin
        phase = PH_RX_LAST;
        add(ACT_RXNAK, 8'd0, rxd, rxv, 1'b0, ERR_OK, 1'b1);
      end
    endfunction

    function void next_write(logic [7:0] tx);
      if (bytes_left == 8'd0) begin
        finish_ok(8'd0, 1'b0);
      end else begin
        bytes_left = bytes_left - 8'd1;
        phase = PH_DATA;
        add(ACT_SEND, tx, 8'd0, 1'b0, 1'b0, ERR_OK, 1'b1);
      end
    endfunction

    function void predict_actions(req_t it);
      logic [7:0] st;
      st = it.bus_status & StMask;
      n_items++;
      case (it.command)
        CMD_BEGIN_RD, CMD_BEGIN_WR: begin
          if (phase == PH_IDLE) begin
            is_read     = (it.command == CMD_BEGIN_RD);
            addr_byte   = {it.slave_address, is_read};
            bytes_left  = (is_read && it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
            stop_wanted = it.send_stop;
            phase       = PH_START;
            add(ACT_START, 8'd0, 8'd0, 1'b0, 1'b0, ERR_OK, 1'b1);
          end
        end
        CMD_EVENT: begin
          if (phase != PH_IDLE && st != wanted_status()) begin
            case (phase)
              PH_START: abort(ERR_START);
              PH_ADDR:  abort(ERR_ADDR);
              PH_DATA:  abort(ERR_DATA);
              PH_RX_ACK: abort(ERR_RXACK);
              default:  abort(ERR_RXLAST);
            endcase
          end else begin
            case (phase)
              PH_START: begin
                phase = PH_ADDR;
                add(ACT_SEND, addr_byte, 8'd0, 1'b0, 1'b0, ERR_OK, 1'b1);
              end
              PH_ADDR: begin
                if (is_read) next_read(8'd0, 1'b0);
                else next_write(it.tx_byte);
              end
              PH_DATA: next_write(it.tx_byte);
              PH_RX_ACK: begin
                bytes_left = bytes_left - 8'd1;
                n_rx++;
                next_read(it.rx_byte, 1'b1);
              end
              PH_RX_LAST: begin
                bytes_left = 8'd0;
                n_rx++;
                finish_ok(it.rx_byte, 1'b1);
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_action(res_t got);
      res_t want;
      n_results++;
      if (actions_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = actions_due.pop_front();
      check_field("bus_action", 8'(want.bus_action), 8'(got.bus_action));
      check_field("action_byte", want.action_byte, got.action_byte);
      check_field("rx_data", want.rx_data, got.rx_data);
      check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("error_code", 8'(want.error_code), 8'(got.error_code));
      check_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  req_t req_i;
  logic empty;
  logic pop;
  res_t res_o;

  seq_tracker  tracker = new();
  bit          burst;
  int unsigned n_sent;
  int unsigned quiet_cycles;

  i2c_master_transaction_sequencer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function req_t rand_req();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    rand_req = raw[$bits(req_t)-1:0];
  endfunction

  function req_t make_begin(bit rd, logic [6:0] addr, logic [7:0] cnt, bit stp);
    req_t r;
    r = rand_req();
    r.command       = rd ? CMD_BEGIN_RD : CMD_BEGIN_WR;
    r.slave_address = addr;
    r.byte_count    = cnt;
    r.send_stop     = stp;
    make_begin = r;
  endfunction

  function req_t make_event(bit good);
    req_t r;
    r = rand_req();
    r.command = CMD_EVENT;
    if (good) begin
      r.bus_status = tracker.wanted_status() | 8'($urandom_range(0, 7));
    end else begin
      do begin
        if ($urandom_range(0, 1) == 1)
          r.bus_status = {5'($urandom_range(1, 11)), 3'($urandom)};
        else
          r.bus_status = 8'($urandom);
      end while ((r.bus_status & StMask) == tracker.wanted_status());
    end
    make_event = r;
  endfunction

  function req_t make_ignored();
    req_t r;
    r = rand_req();
    if (tracker.phase == PH_IDLE) begin
      r.command = ($urandom_range(0, 1) == 1) ? CMD_NONE : CMD_EVENT;
    end else begin
      case ($urandom_range(0, 2))
        0: r.command = CMD_BEGIN_RD;
        1: r.command = CMD_BEGIN_WR;
        default: r.command = CMD_NONE;
      endcase
    end
    make_ignored = r;
  endfunction

  task automatic send_item(req_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.predict_actions(it);
    n_sent++;
  endtask

  task automatic drive_events(int fail_at, bit noisy);
    int k;
    k = 0;
    while (tracker.phase != PH_IDLE) begin
      if (noisy && $urandom_range(0, 11) == 0) send_item(make_ignored());
      send_item(make_event(k != fail_at));
      k++;
    end
  endtask

  task automatic run_txn(bit rd, logic [6:0] addr, logic [7:0] cnt, bit stp, int fail_at,
                         bit noisy);
    send_item(make_begin(rd, addr, cnt, stp));
    drive_events(fail_at, noisy);
  endtask

  initial begin
    int unsigned target;
    int          fail_at;
    logic [7:0]  cnt;
    bit          paused;
    req_t        r;
    rst_ni = 1'b0;
    push   = 1'b0;
    req_i  = '0;
    burst  = 1'b0;
    n_sent = 0;
    paused = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    r = rand_req();
    r.command    = CMD_EVENT;
    r.bus_status = StStart;
    send_item(r);
    r.command = CMD_NONE;
    send_item(r);
    run_txn(1'b0, 7'h7F, 8'd0, 1'b1, -1, 1'b0);
    run_txn(1'b1, 7'h00, 8'd0, 1'b0, -1, 1'b0);
    send_item(make_begin(1'b0, 7'h55, 8'd1, 1'b0));
    send_item(make_begin(1'b1, 7'h2A, 8'd9, 1'b1));
    drive_events(2, 1'b0);
    run_txn(1'b1, 7'h2A, 8'd2, 1'b1, 2, 1'b0);
    run_txn(1'b1, 7'h33, 8'd1, 1'b1, 2, 1'b0);
    run_txn(1'b0, 7'h01, 8'hFF, 1'b1, 0, 1'b0);
    run_txn(1'b1, 7'h7E, 8'hFF, 1'b0, 1, 1'b0);

    target = 160;
    while (n_sent < target) begin
      burst = ($urandom_range(0, 3) == 0);
      if (!paused && n_sent + 80 > target) begin
        push <= 1'b0;
        @(posedge clk_i);
        while (tracker.actions_due.size() != 0) @(posedge clk_i);
        paused = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_item(make_ignored());
      end else begin
        cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        fail_at = -1;
        if (cnt > 8'd6 || $urandom_range(0, 3) == 0)
          fail_at = $urandom_range(0, (cnt > 8'd6) ? 6 : int'(cnt) + 2);
        run_txn(1'($urandom_range(0, 1)), 7'($urandom), cnt, 1'($urandom_range(0, 1)),
                fail_at, 1'b1);
      end
    end
    push <= 1'b0;

    @(posedge clk_i);
    while (tracker.actions_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d items in, %0d results checked, %0d aborted transactions,",
             tracker.n_items, tracker.n_results, tracker.n_aborts);
    $display("and %0d received bytes over reads, writes and repeated starts.", tracker.n_rx);
    if (tracker.errors == 0 && tracker.actions_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int gap;
    int calm;
    pop  = 1'b0;
    calm = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      tracker.check_action(res_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

endmodule
